// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define TC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define TC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `TC_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== src/tri_cov_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle coverage package
// Fixed widths, register indexes and the sideband type of the pipeline.
// ----------------------------------------------------------------------------
package tri_cov_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int RESULT_W      = 32;
  localparam int QUOT_W        = RESULT_W + 1;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 8;
  localparam int EDGE_STAGES   = 3;
  localparam int INTERP_STAGES = 3;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = 8'd2;

  typedef struct packed {
    logic valid;
    logic covered;
    logic degen;
  } side_t;

endpackage

// ===== src/tri_cov_setup.sv =====
// ----------------------------------------------------------------------------
// Triangle setup
// Vertex registers, edge vectors, tie flags and the doubled triangle area.
// ----------------------------------------------------------------------------
module tri_cov_setup #(
  parameter int CB = 16,
  parameter int AB = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [tri_cov_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tri_cov_pkg::CFG_W-1:0]       cfg_data_i,
  output logic signed [CB-1:0]                px_o [3],
  output logic signed [CB-1:0]                py_o [3],
  output logic signed [AB-1:0]                pz_o [3],
  output logic signed [AB-1:0]                pw_o [3],
  output logic signed [CB:0]                  ex_o [3],
  output logic signed [CB:0]                  ey_o [3],
  output logic                                tie_o [3],
  output logic [CB+((CB > tri_cov_pkg::SAMPLE_W) ? CB : tri_cov_pkg::SAMPLE_W)+2:0] dabs_o,
  output logic                                area_neg_o,
  output logic                                degen_o
);

  localparam int SW = ((CB > tri_cov_pkg::SAMPLE_W) ? CB : tri_cov_pkg::SAMPLE_W) + 1;
  localparam int EW = CB + SW + 2;
  localparam int AW = 2 * CB + 3;

  logic [tri_cov_pkg::CFG_W-1:0]   vtx_q [3];
  logic [tri_cov_pkg::CFG_W-1:0]   vtx_d [3];
  logic [2*tri_cov_pkg::CFG_W-1:0] wide  [3];
  logic signed [CB:0]              ex_d  [3];
  logic signed [CB:0]              ey_d  [3];
  logic                            tie_d [3];
  logic signed [AW-1:0]            area_d;
  logic signed [CB:0]              ex_q  [3];
  logic signed [CB:0]              ey_q  [3];
  logic                            tie_q [3];
  logic signed [AW-1:0]            area_q;
  logic signed [EW:0]              area_ext;
  logic signed [EW:0]              area_abs;
  logic [EW-1:0]                   dabs_q;
  logic                            area_neg_q;
  logic                            degen_q;

  always_comb begin
    vtx_d = vtx_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        tri_cov_pkg::REG_VERTEX_A: vtx_d[0] = cfg_data_i;
        tri_cov_pkg::REG_VERTEX_B: vtx_d[1] = cfg_data_i;
        tri_cov_pkg::REG_VERTEX_C: vtx_d[2] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_q <= '{default: '0};
    end else begin
      vtx_q <= vtx_d;
    end
  end

  // Fields above bit 63 of a register read as zero.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {{tri_cov_pkg::CFG_W{1'b0}}, vtx_q[i]};
      px_o[i] = wide[i][0 +: CB];
      py_o[i] = wide[i][CB +: CB];
      pz_o[i] = wide[i][2*CB +: AB];
      pw_o[i] = wide[i][2*CB+AB +: AB];
    end
  end

  always_comb begin
    ex_d[0] = (CB+1)'(px_o[1]) - (CB+1)'(px_o[0]);
    ex_d[1] = (CB+1)'(px_o[2]) - (CB+1)'(px_o[1]);
    ex_d[2] = (CB+1)'(px_o[0]) - (CB+1)'(px_o[2]);
    ey_d[0] = (CB+1)'(py_o[1]) - (CB+1)'(py_o[0]);
    ey_d[1] = (CB+1)'(py_o[2]) - (CB+1)'(py_o[1]);
    ey_d[2] = (CB+1)'(py_o[0]) - (CB+1)'(py_o[2]);
    for (int i = 0; i < 3; i++) begin
      tie_d[i] = (ey_d[i] < 0) || ((ey_d[i] == 0) && (ex_d[i] > 0));
    end
    area_d = AW'(ex_d[0] * ey_d[1]) - AW'(ey_d[0] * ex_d[1]);
  end

  always_ff @(posedge clk_i) begin
    ex_q   <= ex_d;
    ey_q   <= ey_d;
    tie_q  <= tie_d;
    area_q <= area_d;
  end

  always_comb begin
    area_ext = (EW+1)'(area_q);
    area_abs = (area_ext < 0) ? -area_ext : area_ext;
  end

  always_ff @(posedge clk_i) begin
    dabs_q     <= area_abs[EW-1:0];
    area_neg_q <= area_q < 0;
    degen_q    <= area_q == 0;
  end

  assign ex_o       = ex_q;
  assign ey_o       = ey_q;
  assign tie_o      = tie_q;
  assign dabs_o     = dabs_q;
  assign area_neg_o = area_neg_q;
  assign degen_o    = degen_q;

endmodule

// ===== src/tri_cov_edge.sv =====
// ----------------------------------------------------------------------------
// Edge function pipeline
// Three stages: sample offsets, cross products, edge values and coverage.
// ----------------------------------------------------------------------------
module tri_cov_edge #(
  parameter int CB = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  input  logic signed [tri_cov_pkg::SAMPLE_W-1:0]  sample_x_i,
  input  logic signed [tri_cov_pkg::SAMPLE_W-1:0]  sample_y_i,
  input  logic signed [CB-1:0]                     px_i [3],
  input  logic signed [CB-1:0]                     py_i [3],
  input  logic signed [CB:0]                       ex_i [3],
  input  logic signed [CB:0]                       ey_i [3],
  input  logic                                     tie_i [3],
  output logic                                     valid_o,
  output logic                                     covered_o,
  output logic signed [CB+((CB > tri_cov_pkg::SAMPLE_W) ? CB : tri_cov_pkg::SAMPLE_W)+2:0]
                                                   e_o [3]
);

  localparam int SW = ((CB > tri_cov_pkg::SAMPLE_W) ? CB : tri_cov_pkg::SAMPLE_W) + 1;
  localparam int MW = CB + 1 + SW;
  localparam int EW = CB + SW + 2;

  logic [2:0]           vld_q;
  logic signed [SW-1:0] sdx_q [3];
  logic signed [SW-1:0] sdy_q [3];
  logic signed [MW-1:0] m1_q  [3];
  logic signed [MW-1:0] m2_q  [3];
  logic signed [EW-1:0] e_d   [3];
  logic signed [EW-1:0] e_q   [3];
  logic                 cov_d;
  logic                 cov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_comb begin
    cov_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      e_d[i] = EW'(m1_q[i]) - EW'(m2_q[i]);
      if (!((e_d[i] > 0) || ((e_d[i] == 0) && tie_i[i]))) begin
        cov_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sdx_q[i] <= SW'(sample_x_i) - SW'(px_i[i]);
      sdy_q[i] <= SW'(sample_y_i) - SW'(py_i[i]);
      m1_q[i]  <= MW'(ex_i[i]) * MW'(sdy_q[i]);
      m2_q[i]  <= MW'(ey_i[i]) * MW'(sdx_q[i]);
    end
    e_q   <= e_d;
    cov_q <= cov_d;
  end

  assign valid_o   = vld_q[2];
  assign covered_o = cov_q;
  assign e_o       = e_q;

endmodule

// ===== src/tri_cov_interp.sv =====
// ----------------------------------------------------------------------------
// Interpolation numerators
// Three stages: weighted products, sums, and magnitude with rounding bias.
// ----------------------------------------------------------------------------
module tri_cov_interp #(
  parameter int CB = 16,
  parameter int AB = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic                 covered_i,
  input  logic signed [CB+((CB > tri_cov_pkg::SAMPLE_W) ? CB : tri_cov_pkg::SAMPLE_W)+2:0]
                               e_i [3],
  input  logic signed [AB-1:0] pz_i [3],
  input  logic signed [AB-1:0] pw_i [3],
  input  logic [CB+((CB > tri_cov_pkg::SAMPLE_W) ? CB : tri_cov_pkg::SAMPLE_W)+2:0] dabs_i,
  input  logic                 area_neg_i,
  input  logic                 degen_i,
  output tri_cov_pkg::side_t   side_o,
  output logic [AB+CB+((CB > tri_cov_pkg::SAMPLE_W) ? CB : tri_cov_pkg::SAMPLE_W)+5:0] nz_o,
  output logic [AB+CB+((CB > tri_cov_pkg::SAMPLE_W) ? CB : tri_cov_pkg::SAMPLE_W)+5:0] nw_o,
  output logic                 negz_o,
  output logic                 negw_o
);

  localparam int SW  = ((CB > tri_cov_pkg::SAMPLE_W) ? CB : tri_cov_pkg::SAMPLE_W) + 1;
  localparam int EW  = CB + SW + 2;
  localparam int PW  = AB + EW;
  localparam int NW  = PW + 2;
  localparam int NNW = NW + 1;

  tri_cov_pkg::side_t   side_q [3];
  tri_cov_pkg::side_t   side_d;
  logic signed [PW-1:0] pzq [3];
  logic signed [PW-1:0] pwq [3];
  logic signed [NW-1:0] sz_q;
  logic signed [NW-1:0] sw_q;
  logic signed [NW:0]   absz;
  logic signed [NW:0]   absw;
  logic [NNW-1:0]       nz_q;
  logic [NNW-1:0]       nw_q;
  logic                 negz_q;
  logic                 negw_q;

  always_comb begin
    side_d.valid   = valid_i;
    side_d.covered = covered_i;
    side_d.degen   = degen_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '{default: '0};
    end else begin
      side_q[0] <= side_d;
      side_q[1] <= side_q[0];
      side_q[2] <= side_q[1];
    end
  end

  // Vertex i is weighted by the edge opposite to it.
  always_ff @(posedge clk_i) begin
    pzq[0] <= PW'(pz_i[0]) * PW'(e_i[1]);
    pzq[1] <= PW'(pz_i[1]) * PW'(e_i[2]);
    pzq[2] <= PW'(pz_i[2]) * PW'(e_i[0]);
    pwq[0] <= PW'(pw_i[0]) * PW'(e_i[1]);
    pwq[1] <= PW'(pw_i[1]) * PW'(e_i[2]);
    pwq[2] <= PW'(pw_i[2]) * PW'(e_i[0]);
    sz_q   <= NW'(pzq[0]) + NW'(pzq[1]) + NW'(pzq[2]);
    sw_q   <= NW'(pwq[0]) + NW'(pwq[1]) + NW'(pwq[2]);
  end

  always_comb begin
    absz = (sz_q < 0) ? -((NW+1)'(sz_q)) : (NW+1)'(sz_q);
    absw = (sw_q < 0) ? -((NW+1)'(sw_q)) : (NW+1)'(sw_q);
  end

  // Numerator 2|n| + |area| over 2|area| rounds to nearest, ties away from zero.
  always_ff @(posedge clk_i) begin
    nz_q   <= {absz[NW-1:0], 1'b0} + NNW'(dabs_i);
    nw_q   <= {absw[NW-1:0], 1'b0} + NNW'(dabs_i);
    negz_q <= (sz_q < 0) ^ area_neg_i;
    negw_q <= (sw_q < 0) ^ area_neg_i;
  end

  assign side_o = side_q[2];
  assign nz_o   = nz_q;
  assign nw_o   = nw_q;
  assign negz_o = negz_q;
  assign negw_o = negw_q;

endmodule

// ===== src/tri_cov_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per stage, two lanes, then saturation.
// ----------------------------------------------------------------------------
module tri_cov_div #(
  parameter int NNW = 56,
  parameter int DW  = 35
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tri_cov_pkg::side_t                  side_i,
  input  logic [NNW-1:0]                      nz_i,
  input  logic [NNW-1:0]                      nw_i,
  input  logic                                negz_i,
  input  logic                                negw_i,
  input  logic [DW-1:0]                       dabs_i,
  output tri_cov_pkg::side_t                  side_o,
  output logic [tri_cov_pkg::RESULT_W-1:0]    depth_o,
  output logic [tri_cov_pkg::RESULT_W-1:0]    homog_o
);

  localparam int QW = tri_cov_pkg::QUOT_W;
  localparam int RW = NNW + QW;
  localparam int OW = tri_cov_pkg::RESULT_W;

  logic [DW:0]        dd;
  logic [RW-1:0]      dtop;
  tri_cov_pkg::side_t side_q [QW+1];
  logic [NNW-1:0]     rz_q   [QW+1];
  logic [NNW-1:0]     rw_q   [QW+1];
  logic [QW-1:0]      qz_q   [QW+1];
  logic [QW-1:0]      qw_q   [QW+1];
  logic               ovz_q  [QW+1];
  logic               ovw_q  [QW+1];
  logic               negz_q [QW+1];
  logic               negw_q [QW+1];
  tri_cov_pkg::side_t side_out_q;
  logic [OW-1:0]      depth_q;
  logic [OW-1:0]      homog_q;

  function automatic logic [OW-1:0] saturate(input logic [QW-1:0] q, input logic ovf,
                                             input logic neg, input logic degen);
    logic          big;
    logic [OW-1:0] res;
    big = ovf | q[QW-1] | q[QW-2];
    if (degen) begin
      res = '0;
    end else if (!neg) begin
      res = big ? {1'b0, {(OW-1){1'b1}}} : q[OW-1:0];
    end else begin
      res = big ? {1'b1, {(OW-1){1'b0}}} : -q[OW-1:0];
    end
    return res;
  endfunction

  assign dd   = {dabs_i, 1'b0};
  assign dtop = RW'(dd) << QW;

  // Entry: a quotient of 2^QW or more saturates either way.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q[0] <= '0;
    end else begin
      side_q[0] <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rz_q[0]   <= nz_i;
    rw_q[0]   <= nw_i;
    qz_q[0]   <= '0;
    qw_q[0]   <= '0;
    ovz_q[0]  <= RW'(nz_i) >= dtop;
    ovw_q[0]  <= RW'(nw_i) >= dtop;
    negz_q[0] <= negz_i;
    negw_q[0] <= negw_i;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;
    logic [RW-1:0] t;
    assign t = RW'(dd) << K;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s+1] <= '0;
      end else begin
        side_q[s+1] <= side_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (RW'(rz_q[s]) >= t) begin
        rz_q[s+1] <= rz_q[s] - t[NNW-1:0];
        qz_q[s+1] <= qz_q[s] | (QW'(1) << K);
      end else begin
        rz_q[s+1] <= rz_q[s];
        qz_q[s+1] <= qz_q[s];
      end
      if (RW'(rw_q[s]) >= t) begin
        rw_q[s+1] <= rw_q[s] - t[NNW-1:0];
        qw_q[s+1] <= qw_q[s] | (QW'(1) << K);
      end else begin
        rw_q[s+1] <= rw_q[s];
        qw_q[s+1] <= qw_q[s];
      end
      ovz_q[s+1]  <= ovz_q[s];
      ovw_q[s+1]  <= ovw_q[s];
      negz_q[s+1] <= negz_q[s];
      negw_q[s+1] <= negw_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_out_q <= '0;
    end else begin
      side_out_q <= side_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    depth_q <= saturate(qz_q[QW], ovz_q[QW], negz_q[QW], side_q[QW].degen);
    homog_q <= saturate(qw_q[QW], ovw_q[QW], negw_q[QW], side_q[QW].degen);
  end

  assign side_o  = side_out_q;
  assign depth_o = depth_q;
  assign homog_o = homog_q;

endmodule

// ===== src/triangle_coverage_interpolate.sv =====
// ----------------------------------------------------------------------------
// Triangle coverage and depth interpolation
// Edge-function coverage test with top-left tie rule and linear z/w values.
// ----------------------------------------------------------------------------
// One sample is accepted in every clock cycle after reset (busy is high only
// while reset is applied and until the first clock edge after it). Each sample
// produces one result word, marked by done_o for a single cycle; the receiver
// cannot stall, so results must be taken when they appear. The path runs
// through the edge-function stages, the interpolation stages, and a
// restoring divider that resolves one quotient bit per stage over 33 stages
// plus an entry and an output stage. Vertex registers are written through the
// configuration channel, which is always ready; writes are meant to happen
// while no sample is in flight, and a sample may start on the cycle after
// the last write.
module triangle_coverage_interpolate #(
  parameter int COORD_BITS = 16,
  parameter int ATTR_BITS  = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [tri_cov_pkg::SAMPLE_W-1:0]  sample_x_i,
  input  logic signed [tri_cov_pkg::SAMPLE_W-1:0]  sample_y_i,
  output logic                                     done_o,
  output logic                                     covered_o,
  output logic signed [tri_cov_pkg::RESULT_W-1:0]  depth_value_o,
  output logic signed [tri_cov_pkg::RESULT_W-1:0]  homog_value_o,
  output logic                                     degenerate_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [tri_cov_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [tri_cov_pkg::CFG_W-1:0]            cfg_data_i
);

`include "assert_macros.svh"

  localparam int CB  = COORD_BITS;
  localparam int AB  = ATTR_BITS;
  localparam int SW  = ((CB > tri_cov_pkg::SAMPLE_W) ? CB : tri_cov_pkg::SAMPLE_W) + 1;
  localparam int EW  = CB + SW + 2;
  localparam int NNW = AB + EW + 3;
  localparam int LAT = tri_cov_pkg::EDGE_STAGES + tri_cov_pkg::INTERP_STAGES
                       + tri_cov_pkg::QUOT_W + 2;

  logic                 busy_q;
  logic                 accept;
  logic signed [CB-1:0] px [3];
  logic signed [CB-1:0] py [3];
  logic signed [AB-1:0] pz [3];
  logic signed [AB-1:0] pw [3];
  logic signed [CB:0]   ex [3];
  logic signed [CB:0]   ey [3];
  logic                 tie [3];
  logic [EW-1:0]        dabs;
  logic                 area_neg;
  logic                 degen;
  logic                 edge_valid;
  logic                 edge_covered;
  logic signed [EW-1:0] edge_val [3];
  tri_cov_pkg::side_t   num_side;
  logic [NNW-1:0]       nz;
  logic [NNW-1:0]       nw;
  logic                 negz;
  logic                 negw;
  tri_cov_pkg::side_t   res_side;
  logic [tri_cov_pkg::RESULT_W-1:0] depth;
  logic [tri_cov_pkg::RESULT_W-1:0] homog;

  // Busy holds samples off through reset; the pipeline itself never stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy        = busy_q;
  assign accept      = start && !busy_q;
  assign cfg_ready_o = 1'b1;

  // Per-triangle setup: the edge vectors are registered from the vertex registers,
  // the area magnitude in a further register, ahead of the stages that first read them.
  tri_cov_setup #(.CB(CB), .AB(AB)) u_setup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .px_o       (px),
    .py_o       (py),
    .pz_o       (pz),
    .pw_o       (pw),
    .ex_o       (ex),
    .ey_o       (ey),
    .tie_o      (tie),
    .dabs_o     (dabs),
    .area_neg_o (area_neg),
    .degen_o    (degen)
  );

  tri_cov_edge #(.CB(CB)) u_edge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .sample_x_i(sample_x_i),
    .sample_y_i(sample_y_i),
    .px_i      (px),
    .py_i      (py),
    .ex_i      (ex),
    .ey_i      (ey),
    .tie_i     (tie),
    .valid_o   (edge_valid),
    .covered_o (edge_covered),
    .e_o       (edge_val)
  );

  tri_cov_interp #(.CB(CB), .AB(AB)) u_interp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (edge_valid),
    .covered_i (edge_covered),
    .e_i       (edge_val),
    .pz_i      (pz),
    .pw_i      (pw),
    .dabs_i    (dabs),
    .area_neg_i(area_neg),
    .degen_i   (degen),
    .side_o    (num_side),
    .nz_o      (nz),
    .nw_o      (nw),
    .negz_o    (negz),
    .negw_o    (negw)
  );

  // The divisor is twice the absolute area; the numerator carries the
  // rounding bias, so the floor quotient is already rounded.
  tri_cov_div #(.NNW(NNW), .DW(EW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (num_side),
    .nz_i   (nz),
    .nw_i   (nw),
    .negz_i (negz),
    .negw_i (negw),
    .dabs_i (dabs),
    .side_o (res_side),
    .depth_o(depth),
    .homog_o(homog)
  );

  assign done_o        = res_side.valid;
  assign covered_o     = res_side.covered;
  assign degenerate_o  = res_side.degen;
  assign depth_value_o = depth;
  assign homog_value_o = homog;

  `TC_ASSERT(a_fixed_latency, clk_i, rst_ni, done_o == $past(accept, LAT), "result strobe out of step with accepted samples")
  `TC_ASSERT_NEVER(a_degen_zero, clk_i, rst_ni, done_o && degenerate_o && ((depth_value_o != 0) || (homog_value_o != 0)), "degenerate triangle gave nonzero values")
  `TC_ASSERT_NEVER(a_degen_uncovered, clk_i, rst_ni, done_o && degenerate_o && covered_o, "degenerate triangle reported coverage")

endmodule
